// ===== rtl/scaled_sprite_blit_address_gen_defines.svh =====
// Assertion helpers shared by the block's modules.
// Every check is clocked on the rising edge and held off while reset is low.
`ifndef SCALED_SPRITE_BLIT_ADDRESS_GEN_DEFINES_SVH
`define SCALED_SPRITE_BLIT_ADDRESS_GEN_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSBAG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSBAG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ssbag_pkg.sv =====
`timescale 1ns / 1ps

package ssbag_pkg;

  // Largest sprite or atlas dimension the block is sized for.
  localparam int MAX_DIM   = 4096;

  // Field widths.
  localparam int COORD_W   = 12;
  localparam int DIM_W     = 13;
  localparam int INDEX_W   = 24;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 1;

  // Counters and accumulated positions can reach twice a coordinate.
  localparam int ABS_W     = DIM_W + 1;
  localparam int DIV_CNT_W = $clog2(DIM_W + 1);

  localparam logic [DIM_W-1:0] ATLAS_RESET = DIM_W'(MAX_DIM);

  // Item kinds on the request channel.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_HEIGHT = CFG_IDX_W'(1);

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_PAIR       = 3'd0,
    ST_ACCEPT     = 3'd1,
    ST_ZERO_SIZE  = 3'd2,
    ST_OUTSIDE    = 3'd3,
    ST_EMPTY_CROP = 3'd4,
    ST_IDLE       = 3'd5
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;     // a load transaction was accepted
    logic    capture;  // the load is valid: latch it and start the dividers
    logic    commit;   // dividers finished: store the step terms, go active
    logic    emit;     // write the response register
    status_e code;     // status written with emit
    logic    step;     // advance the pixel walk
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    status_e load_code;  // outcome of checking the presented descriptor
    logic    active;
    logic    div_done;
  } dp_stat_t;

endpackage

// ===== rtl/ssbag_ifs.sv =====
`timescale 1ns / 1ps

// Request channel: descriptor loads and pixel steps.
interface ssbag_req_if import ssbag_pkg::*;;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [COORD_W-1:0] dest_x;
  logic [COORD_W-1:0] dest_y;
  logic [DIM_W-1:0]   dest_w;
  logic [DIM_W-1:0]   dest_h;
  logic [COORD_W-1:0] crop_left;
  logic [COORD_W-1:0] crop_top;
  logic [COORD_W-1:0] crop_right;
  logic [COORD_W-1:0] crop_bottom;
  logic               use_crop;
  logic [DIM_W-1:0]   image_w;
  logic [DIM_W-1:0]   image_h;

  modport source (
    output valid, kind, dest_x, dest_y, dest_w, dest_h, crop_left, crop_top,
           crop_right, crop_bottom, use_crop, image_w, image_h,
    input  ready
  );
  modport sink (
    input  valid, kind, dest_x, dest_y, dest_w, dest_h, crop_left, crop_top,
           crop_right, crop_bottom, use_crop, image_w, image_h,
    output ready
  );
endinterface

// Response channel: one result per request.
interface ssbag_rsp_if import ssbag_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  dest_index;
  logic [INDEX_W-1:0]  src_index;
  logic                last;

  modport source (
    output valid, status, dest_index, src_index, last,
    input  ready
  );
  modport sink (
    input  valid, status, dest_index, src_index, last,
    output ready
  );
endinterface

// ===== rtl/ssbag_div.sv =====
`timescale 1ns / 1ps
`include "scaled_sprite_blit_address_gen_defines.svh"

// Restoring divider, one quotient bit per cycle.
module ssbag_div import ssbag_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIM_W-1:0] dividend_i,
  input  logic [DIM_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIM_W-1:0] quot_o,
  output logic [DIM_W-1:0] rem_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIM_W-1:0]     rem_q, quot_q, divisor_q;
  logic [DIM_W:0]       shifted;
  logic [DIM_W:0]       diff;
  logic                 fits;

  // Bring down the next dividend bit and try to subtract the divisor.
  assign shifted = {rem_q, quot_q[DIM_W-1]};
  assign diff    = shifted - {1'b0, divisor_q};
  assign fits    = shifted >= {1'b0, divisor_q};

  // Control: busy flag, bit counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= '0;
      quot_q    <= dividend_i;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= fits ? diff[DIM_W-1:0] : shifted[DIM_W-1:0];
      quot_q <= {quot_q[DIM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

  `SSBAG_ASSERT_NOW(a_no_restart, clk_i, rst_ni, busy_q, !start_i,
    "divider restarted while busy")
  `SSBAG_ASSERT_NEXT(a_done_ends, clk_i, rst_ni, done_q, !busy_q && !done_q,
    "divider done pulse longer than one cycle")
  `SSBAG_ASSERT_NOW(a_rem_bound, clk_i, rst_ni, done_q && divisor_q != '0,
    rem_q < divisor_q, "divider remainder not below divisor")

endmodule

// ===== rtl/ssbag_ctrl.sv =====
`timescale 1ns / 1ps
`include "scaled_sprite_blit_address_gen_defines.svh"

// Controller: handshakes and the load sequence.
module ssbag_ctrl import ssbag_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_kind_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  dp_stat_t  stat_i,
  output ctl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_READY,
    S_DIV,
    S_REPLY
  } state_e;

  state_e   state_q, state_d;
  logic     out_valid_q, out_valid_d;
  logic     out_free;
  ctl_cmd_t cmd;

  // The response register can take a new value when empty or being drained.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_READY) && out_free;

  // Next state and datapath commands.
  always_comb begin
    cmd         = '0;
    cmd.code    = ST_PAIR;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_READY: begin
        if (in_valid_i && in_ready_o) begin
          if (in_kind_i == KIND_STEP) begin
            cmd.emit = 1'b1;
            cmd.code = stat_i.active ? ST_PAIR : ST_IDLE;
            cmd.step = stat_i.active;
          end else begin
            cmd.load = 1'b1;
            if (stat_i.load_code == ST_ACCEPT) begin
              cmd.capture = 1'b1;
              state_d     = S_DIV;
            end else begin
              cmd.emit = 1'b1;
              cmd.code = stat_i.load_code;
            end
          end
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd.commit = 1'b1;
          state_d    = S_REPLY;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          cmd.code = ST_ACCEPT;
          state_d  = S_READY;
        end
      end
      default: begin
        state_d = S_READY;
      end
    endcase
    if (cmd.emit) begin
      out_valid_d = 1'b1;
    end
  end

  // State and response valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_READY;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `SSBAG_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, out_valid_q && !out_ready_i,
    !cmd.emit, "response overwritten while stalled")
  `SSBAG_ASSERT_NOW(a_done_in_div, clk_i, rst_ni, stat_i.div_done,
    state_q == S_DIV, "divider finished outside the load sequence")
  `SSBAG_ASSERT_NEXT(a_capture_div, clk_i, rst_ni, cmd.capture,
    state_q == S_DIV && !in_ready_o, "load capture did not start the divide")

endmodule

// ===== rtl/ssbag_dp.sv =====
`timescale 1ns / 1ps
`include "scaled_sprite_blit_address_gen_defines.svh"

// Datapath: descriptor check, sprite state, pixel walk and response register.
module ssbag_dp import ssbag_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_wdata_i,
  input  logic [COORD_W-1:0]   dest_x_i,
  input  logic [COORD_W-1:0]   dest_y_i,
  input  logic [DIM_W-1:0]     dest_w_i,
  input  logic [DIM_W-1:0]     dest_h_i,
  input  logic [COORD_W-1:0]   crop_left_i,
  input  logic [COORD_W-1:0]   crop_top_i,
  input  logic [COORD_W-1:0]   crop_right_i,
  input  logic [COORD_W-1:0]   crop_bottom_i,
  input  logic                 use_crop_i,
  input  logic [DIM_W-1:0]     image_w_i,
  input  logic [DIM_W-1:0]     image_h_i,
  input  ctl_cmd_t             cmd_i,
  output dp_stat_t             stat_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [INDEX_W-1:0]   dest_index_o,
  output logic [INDEX_W-1:0]   src_index_o,
  output logic                 last_o
);

  // Configuration and control registers.
  logic [DIM_W-1:0] atlas_w_q, atlas_h_q;
  logic             active_q;

  // Sprite descriptor and walk state.
  logic [COORD_W-1:0] base_x_q, base_y_q;
  logic [DIM_W-1:0]   size_w_q, size_h_q, stride_q;
  logic [DIM_W-1:0]   quot_x_q, rem_x_q, quot_y_q, rem_y_q;
  logic [DIM_W-1:0]   col_q, row_q, err_x_q, err_y_q;
  logic [DIM_W-1:0]   origin_sx_q, sample_sx_q, sample_sy_q;

  // Response register.
  status_e            rsp_status_q;
  logic [INDEX_W-1:0] rsp_dest_q, rsp_src_q;
  logic               rsp_last_q;

  // Descriptor check.
  logic [DIM_W-1:0] cl, ct, cr, cb;
  logic [DIM_W-1:0] crop_w_sum, crop_h_sum, src_w, src_h;
  logic             zero_size, outside, empty_crop;
  status_e          load_code;

  assign cl = use_crop_i ? DIM_W'(crop_left_i)   : '0;
  assign ct = use_crop_i ? DIM_W'(crop_top_i)    : '0;
  assign cr = use_crop_i ? DIM_W'(crop_right_i)  : '0;
  assign cb = use_crop_i ? DIM_W'(crop_bottom_i) : '0;

  assign crop_w_sum = cl + cr;
  assign crop_h_sum = ct + cb;
  assign src_w      = image_w_i - crop_w_sum;
  assign src_h      = image_h_i - crop_h_sum;

  assign zero_size  = (dest_w_i == '0) || (dest_h_i == '0);
  assign outside    = (dest_w_i > atlas_w_q) || (dest_h_i > atlas_h_q) ||
                      (DIM_W'(dest_x_i) > atlas_w_q - dest_w_i) ||
                      (DIM_W'(dest_y_i) > atlas_h_q - dest_h_i);
  assign empty_crop = (crop_w_sum >= image_w_i) || (crop_h_sum >= image_h_i);

  always_comb begin
    if (zero_size) begin
      load_code = ST_ZERO_SIZE;
    end else if (outside) begin
      load_code = ST_OUTSIDE;
    end else if (empty_crop) begin
      load_code = ST_EMPTY_CROP;
    end else begin
      load_code = ST_ACCEPT;
    end
  end

  // Step terms: cropped source size over destination size, per axis.
  logic             div_x_done, div_y_done;
  logic [DIM_W-1:0] div_x_quot, div_x_rem, div_y_quot, div_y_rem;

  ssbag_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.capture),
    .dividend_i (src_w),
    .divisor_i  (dest_w_i),
    .done_o     (div_x_done),
    .quot_o     (div_x_quot),
    .rem_o      (div_x_rem)
  );

  ssbag_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.capture),
    .dividend_i (src_h),
    .divisor_i  (dest_h_i),
    .done_o     (div_y_done),
    .quot_o     (div_y_quot),
    .rem_o      (div_y_rem)
  );

  // Current copy pair.
  logic [ABS_W-1:0]       row_abs, col_abs;
  logic [ABS_W+DIM_W-1:0] dest_prod;
  logic [2*DIM_W-1:0]     src_prod;
  logic [INDEX_W-1:0]     dest_index, src_index;
  logic [DIM_W-1:0]       col_inc, row_inc;
  logic                   row_end, sprite_end, last_pair;

  assign row_abs    = ABS_W'(base_y_q) + ABS_W'(row_q);
  assign col_abs    = ABS_W'(base_x_q) + ABS_W'(col_q);
  assign dest_prod  = row_abs * atlas_w_q;
  assign src_prod   = sample_sy_q * stride_q;
  assign dest_index = dest_prod[INDEX_W-1:0] + INDEX_W'(col_abs);
  assign src_index  = src_prod[INDEX_W-1:0] + INDEX_W'(sample_sx_q);

  assign col_inc    = col_q + DIM_W'(1);
  assign row_inc    = row_q + DIM_W'(1);
  assign row_end    = col_inc >= size_w_q;
  assign sprite_end = row_inc >= size_h_q;
  assign last_pair  = (col_inc == size_w_q) && (row_inc == size_h_q);

  // Error accumulators for the next sample position.
  logic [DIM_W:0] err_x_sum, err_y_sum;
  logic           wrap_x, wrap_y;

  assign err_x_sum = {1'b0, err_x_q} + {1'b0, rem_x_q};
  assign err_y_sum = {1'b0, err_y_q} + {1'b0, rem_y_q};
  assign wrap_x    = err_x_sum >= {1'b0, size_w_q};
  assign wrap_y    = err_y_sum >= {1'b0, size_h_q};

  // Atlas registers and the active flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_w_q <= ATLAS_RESET;
      atlas_h_q <= ATLAS_RESET;
      active_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ATLAS_WIDTH:  atlas_w_q <= cfg_wdata_i;
          REG_ATLAS_HEIGHT: atlas_h_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        active_q <= 1'b0;
      end else if (cmd_i.commit) begin
        active_q <= 1'b1;
      end else if (cmd_i.step && row_end && sprite_end) begin
        active_q <= 1'b0;
      end
    end
  end

  // Descriptor capture, step terms and the pixel walk.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      base_x_q    <= dest_x_i;
      base_y_q    <= dest_y_i;
      size_w_q    <= dest_w_i;
      size_h_q    <= dest_h_i;
      stride_q    <= image_w_i;
      col_q       <= '0;
      row_q       <= '0;
      err_x_q     <= '0;
      err_y_q     <= '0;
      origin_sx_q <= cl;
      sample_sx_q <= cl;
      sample_sy_q <= ct;
    end else if (cmd_i.step) begin
      if (row_end) begin
        col_q       <= '0;
        sample_sx_q <= origin_sx_q;
        err_x_q     <= '0;
        row_q       <= row_inc;
        sample_sy_q <= sample_sy_q + quot_y_q + DIM_W'(wrap_y);
        err_y_q     <= wrap_y ? DIM_W'(err_y_sum - {1'b0, size_h_q})
                              : err_y_sum[DIM_W-1:0];
      end else begin
        col_q       <= col_inc;
        sample_sx_q <= sample_sx_q + quot_x_q + DIM_W'(wrap_x);
        err_x_q     <= wrap_x ? DIM_W'(err_x_sum - {1'b0, size_w_q})
                              : err_x_sum[DIM_W-1:0];
      end
    end
    if (cmd_i.commit) begin
      quot_x_q <= div_x_quot;
      rem_x_q  <= div_x_rem;
      quot_y_q <= div_y_quot;
      rem_y_q  <= div_y_rem;
    end
  end

  // Response register; only a pixel pair carries indexes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rsp_status_q <= cmd_i.code;
      if (cmd_i.code == ST_PAIR) begin
        rsp_dest_q <= dest_index;
        rsp_src_q  <= src_index;
        rsp_last_q <= last_pair;
      end else begin
        rsp_dest_q <= '0;
        rsp_src_q  <= '0;
        rsp_last_q <= 1'b0;
      end
    end
  end

  assign stat_o.load_code = load_code;
  assign stat_o.active    = active_q;
  assign stat_o.div_done  = div_x_done;

  assign status_o     = rsp_status_q;
  assign dest_index_o = rsp_dest_q;
  assign src_index_o  = rsp_src_q;
  assign last_o       = rsp_last_q;

  `SSBAG_ASSERT_NOW(a_div_lockstep, clk_i, rst_ni, div_x_done || div_y_done,
    div_x_done && div_y_done, "axis dividers finished in different cycles")
  `SSBAG_ASSERT_NOW(a_step_active, clk_i, rst_ni, cmd_i.step, active_q,
    "pixel step without an active sprite")
  `SSBAG_ASSERT_NEXT(a_commit_active, clk_i, rst_ni, cmd_i.commit, active_q,
    "committed descriptor did not become active")

endmodule

// ===== rtl/scaled_sprite_blit_address_gen.sv =====
`timescale 1ns / 1ps
// Scaled sprite blit address generator.
// req_i carries two kinds of transaction: a descriptor load (kind 0) and a
// pixel step (kind 1). Every request yields exactly one transaction on rsp_o.
// A load is checked at once; a rejected load answers with its error status
// and drops any sprite in progress. An accepted load runs two 13-bit
// restoring dividers in parallel before its answer (status accepted) leaves;
// no request is taken meanwhile. A step answers in the cycle after
// acceptance with the destination and source pixel indexes, and last on the
// sprite's final pair. One step per cycle is sustained while rsp_o does not
// stall; each index takes a 14x13 (dest) or 13x13 (src) multiply and an add.
// A step with no sprite loaded answers with status idle.
// The atlas registers are written through cfg_we_i, cfg_idx_i, cfg_wdata_i.
// Reset clears the active sprite and sets both atlas registers to 4096.
// When rsp_o stalls, the answer is held and one further request is not
// taken until the response register drains.
module scaled_sprite_blit_address_gen import ssbag_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_wdata_i,
  ssbag_req_if.sink            req_i,
  ssbag_rsp_if.source          rsp_o
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Handshake control and load sequencing.
  ssbag_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_kind_i   (req_i.kind),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Address arithmetic and sprite state.
  ssbag_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .dest_x_i      (req_i.dest_x),
    .dest_y_i      (req_i.dest_y),
    .dest_w_i      (req_i.dest_w),
    .dest_h_i      (req_i.dest_h),
    .crop_left_i   (req_i.crop_left),
    .crop_top_i    (req_i.crop_top),
    .crop_right_i  (req_i.crop_right),
    .crop_bottom_i (req_i.crop_bottom),
    .use_crop_i    (req_i.use_crop),
    .image_w_i     (req_i.image_w),
    .image_h_i     (req_i.image_h),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .status_o      (rsp_o.status),
    .dest_index_o  (rsp_o.dest_index),
    .src_index_o   (rsp_o.src_index),
    .last_o        (rsp_o.last)
  );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb import ssbag_pkg::*; ;

  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 150;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    logic [DIM_W-1:0]   dest_w;
    logic [DIM_W-1:0]   dest_h;
    logic [COORD_W-1:0] crop_left;
    logic [COORD_W-1:0] crop_top;
    logic [COORD_W-1:0] crop_right;
    logic [COORD_W-1:0] crop_bottom;
    logic               use_crop;
    logic [DIM_W-1:0]   image_w;
    logic [DIM_W-1:0]   image_h;
  } copy_req_t;

  typedef struct packed {
    status_e            status;
    logic [INDEX_W-1:0] dest_index;
    logic [INDEX_W-1:0] src_index;
    logic               last;
  } copy_rsp_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DIM_W-1:0]     cfg_wdata_i;

  ssbag_req_if req_if ();
  ssbag_rsp_if rsp_if ();

  scaled_sprite_blit_address_gen i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // Requests waiting to be sent and responses still owed by the block.
  copy_req_t req_backlog[$];
  copy_rsp_t rsp_due[$];
  copy_req_t req_now;
  copy_rsp_t rsp_want;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned mismatches;
  int unsigned hold_req;
  int unsigned hold_ack;
  bit          steady;

  // Shadow of the atlas registers and of the pixel walk.
  logic [DIM_W-1:0] atlas_w = ATLAS_RESET;
  logic [DIM_W-1:0] atlas_h = ATLAS_RESET;
  bit               sprite_on;
  int unsigned      org_x, org_y, span_w, span_h, src_stride;
  int unsigned      quo_x, rem_x, quo_y, rem_y;
  int unsigned      col, row, acc_x, acc_y, left_sx, samp_x, samp_y;

  // Appends one request to the end of the backlog.
  function automatic void add_req(copy_req_t q);
    req_backlog.insert(req_backlog.size(), q);
  endfunction

  function automatic int unsigned umin(int unsigned a, int unsigned b);
    return (a < b) ? a : b;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Computes the response to one accepted transaction and advances the walk.
  function automatic copy_rsp_t next_copy_rsp(copy_req_t q);
    copy_rsp_t       res;
    int unsigned     dx, dy, dw, dh, cl, ct, cr, cb, iw, ih, aw, ah, cw, chh;
    longint unsigned full;
    res = '0;
    res.status = ST_IDLE;
    aw = atlas_w;
    ah = atlas_h;
    if (q.kind == KIND_LOAD) begin
      dx = q.dest_x;
      dy = q.dest_y;
      dw = q.dest_w;
      dh = q.dest_h;
      cl = q.use_crop ? int'(q.crop_left) : 0;
      ct = q.use_crop ? int'(q.crop_top) : 0;
      cr = q.use_crop ? int'(q.crop_right) : 0;
      cb = q.use_crop ? int'(q.crop_bottom) : 0;
      iw = q.image_w;
      ih = q.image_h;
      sprite_on = 1'b0;
      if (dw == 0 || dh == 0) begin
        res.status = ST_ZERO_SIZE;
      end else if (dw > aw || dh > ah || dx > aw - dw || dy > ah - dh) begin
        res.status = ST_OUTSIDE;
      end else if (cl + cr >= iw || ct + cb >= ih) begin
        res.status = ST_EMPTY_CROP;
      end else begin
        cw = iw - cl - cr;
        chh = ih - ct - cb;
        org_x = dx;
        org_y = dy;
        span_w = dw;
        span_h = dh;
        src_stride = iw;
        quo_x = cw / dw;
        rem_x = cw % dw;
        quo_y = chh / dh;
        rem_y = chh % dh;
        col = 0;
        row = 0;
        acc_x = 0;
        acc_y = 0;
        left_sx = cl;
        samp_x = cl;
        samp_y = ct;
        sprite_on = 1'b1;
        res.status = ST_ACCEPT;
      end
    end else if (sprite_on) begin
      res.status = ST_PAIR;
      full = 64'(org_y + row) * 64'(aw) + 64'(org_x + col);
      res.dest_index = full[INDEX_W-1:0];
      full = 64'(samp_y) * 64'(src_stride) + 64'(samp_x);
      res.src_index = full[INDEX_W-1:0];
      res.last = (col + 1 == span_w) && (row + 1 == span_h);
      // Error accumulators give floor(index * crop / size) without a divide.
      col++;
      if (col >= span_w) begin
        col = 0;
        samp_x = left_sx;
        acc_x = 0;
        row++;
        samp_y += quo_y;
        acc_y += rem_y;
        if (acc_y >= span_h) begin
          acc_y -= span_h;
          samp_y++;
        end
        if (row >= span_h) begin
          sprite_on = 1'b0;
        end
      end else begin
        samp_x += quo_x;
        acc_x += rem_x;
        if (acc_x >= span_w) begin
          acc_x -= span_w;
          samp_x++;
        end
      end
    end
    return res;
  endfunction

  // Every field random; steps ignore all but the kind.
  function automatic copy_req_t rand_fields();
    copy_req_t q;
    q.kind        = 1'($urandom);
    q.dest_x      = COORD_W'($urandom);
    q.dest_y      = COORD_W'($urandom);
    q.dest_w      = DIM_W'($urandom);
    q.dest_h      = DIM_W'($urandom);
    q.crop_left   = COORD_W'($urandom);
    q.crop_top    = COORD_W'($urandom);
    q.crop_right  = COORD_W'($urandom);
    q.crop_bottom = COORD_W'($urandom);
    q.use_crop    = 1'($urandom);
    q.image_w     = DIM_W'($urandom);
    q.image_h     = DIM_W'($urandom);
    return q;
  endfunction

  function automatic copy_req_t step_item();
    copy_req_t q;
    q = rand_fields();
    q.kind = KIND_STEP;
    return q;
  endfunction

  function automatic copy_req_t mk_load(int unsigned dx, int unsigned dy, int unsigned dw,
                                        int unsigned dh, bit crop, int unsigned cl,
                                        int unsigned ct, int unsigned cr, int unsigned cb,
                                        int unsigned iw, int unsigned ih);
    copy_req_t q;
    q.kind        = KIND_LOAD;
    q.dest_x      = COORD_W'(dx);
    q.dest_y      = COORD_W'(dy);
    q.dest_w      = DIM_W'(dw);
    q.dest_h      = DIM_W'(dh);
    q.crop_left   = COORD_W'(cl);
    q.crop_top    = COORD_W'(ct);
    q.crop_right  = COORD_W'(cr);
    q.crop_bottom = COORD_W'(cb);
    q.use_crop    = crop;
    q.image_w     = DIM_W'(iw);
    q.image_h     = DIM_W'(ih);
    return q;
  endfunction

  // Destination sizes stay small most of the time so that walks finish.
  function automatic int unsigned pick_span(int unsigned lim);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, umin(lim, 6));
    if (r < 95) return $urandom_range(1, umin(lim, 16));
    return $urandom_range(1, lim);
  endfunction

  function automatic int unsigned pick_image();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(1, 16);
    if (r < 85) return $urandom_range(1, MAX_DIM);
    return $urandom_range(1, 8191);
  endfunction

  // A descriptor that passes every check under the current atlas size.
  function automatic copy_req_t good_load();
    copy_req_t   q;
    int unsigned aw, ah, dw, dh, iw, ih, cl, ct;
    q = rand_fields();
    q.kind = KIND_LOAD;
    aw = atlas_w;
    ah = atlas_h;
    dw = pick_span(aw);
    dh = pick_span(ah);
    iw = pick_image();
    ih = pick_image();
    q.dest_w = DIM_W'(dw);
    q.dest_h = DIM_W'(dh);
    q.dest_x = COORD_W'($urandom_range(0, aw - dw));
    q.dest_y = COORD_W'($urandom_range(0, ah - dh));
    q.image_w = DIM_W'(iw);
    q.image_h = DIM_W'(ih);
    if (q.use_crop) begin
      cl = $urandom_range(0, umin(iw - 1, 4095));
      ct = $urandom_range(0, umin(ih - 1, 4095));
      q.crop_left   = COORD_W'(cl);
      q.crop_top    = COORD_W'(ct);
      q.crop_right  = COORD_W'($urandom_range(0, umin(iw - 1 - cl, 4095)));
      q.crop_bottom = COORD_W'($urandom_range(0, umin(ih - 1 - ct, 4095)));
    end
    return q;
  endfunction

  // A good descriptor pushed just over one edge of one check.
  function automatic copy_req_t bent_load();
    copy_req_t   q;
    int unsigned aw, ah;
    q = good_load();
    aw = atlas_w;
    ah = atlas_h;
    case ($urandom_range(0, 3))
      0: begin
        if ($urandom_range(0, 1) != 0) q.dest_w = '0;
        else q.dest_h = '0;
      end
      1: begin
        if (aw - q.dest_w < 4095) q.dest_x = COORD_W'(aw - q.dest_w + 1);
        else q.dest_w = DIM_W'(aw + 1);
      end
      2: begin
        if (ah - q.dest_h < 4095) q.dest_y = COORD_W'(ah - q.dest_h + 1);
        else q.dest_h = DIM_W'(ah + 1);
      end
      default: begin
        q.use_crop = 1'b1;
        if ($urandom_range(0, 1) != 0) q.image_w = DIM_W'(q.crop_left + q.crop_right);
        else q.image_h = DIM_W'(q.crop_top + q.crop_bottom);
      end
    endcase
    return q;
  endfunction

  // Mostly complete or cut-short sprite walks, the rest noise.
  task automatic queue_phase(int unsigned budget);
    copy_req_t   q;
    int unsigned added, pix, nstep, r;
    added = 0;
    while (added < budget) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        q = good_load();
        add_req(q);
        added++;
        pix = q.dest_w * q.dest_h;
        if (pix <= 64 && $urandom_range(0, 3) != 0) begin
          nstep = pix + $urandom_range(0, 1);
        end else begin
          nstep = $urandom_range(0, umin(pix, 24));
        end
        repeat (nstep) begin
          add_req(step_item());
          added++;
        end
      end else if (r < 85) begin
        q = rand_fields();
        q.kind = KIND_LOAD;
        add_req(q);
        added++;
      end else if (r < 93) begin
        add_req(bent_load());
        added++;
      end else begin
        add_req(step_item());
        added++;
      end
    end
  endtask

  // Returns on a falling edge once nothing is queued, offered or owed.
  task automatic wait_idle();
    @(negedge clk_i);
    while (req_backlog.size() != 0 || req_if.valid || rsp_due.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_atlas(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= DIM_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_ATLAS_WIDTH) begin
      atlas_w = DIM_W'(value);
    end else begin
      atlas_h = DIM_W'(value);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Request driver: predicts each accepted transaction, then offers the next.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      if (req_if.valid) begin
        rsp_due.insert(rsp_due.size(), next_copy_rsp(req_now));
      end
      if (send_gap != 0) begin
        send_gap--;
        req_if.valid <= 1'b0;
      end else if (req_backlog.size() != 0) begin
        req_now = req_backlog.pop_front();
        req_if.kind        <= req_now.kind;
        req_if.dest_x      <= req_now.dest_x;
        req_if.dest_y      <= req_now.dest_y;
        req_if.dest_w      <= req_now.dest_w;
        req_if.dest_h      <= req_now.dest_h;
        req_if.crop_left   <= req_now.crop_left;
        req_if.crop_top    <= req_now.crop_top;
        req_if.crop_right  <= req_now.crop_right;
        req_if.crop_bottom <= req_now.crop_bottom;
        req_if.use_crop    <= req_now.use_crop;
        req_if.image_w     <= req_now.image_w;
        req_if.image_h     <= req_now.image_h;
        req_if.valid       <= 1'b1;
        send_gap = steady ? 0 : pick_gap();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response monitor: checks each transaction against the oldest prediction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (rsp_due.size() == 0) begin
          $display("%0t: unexpected response status %0d dest %06h src %06h last %0b",
                   $time, rsp_if.status, rsp_if.dest_index, rsp_if.src_index,
                   rsp_if.last);
          mismatches++;
        end else begin
          rsp_want = rsp_due.pop_front();
          if (rsp_if.status !== rsp_want.status ||
              rsp_if.dest_index !== rsp_want.dest_index ||
              rsp_if.src_index !== rsp_want.src_index ||
              rsp_if.last !== rsp_want.last) begin
            $display("%0t: mismatch expected status %0d dest %06h src %06h last %0b",
                     $time, rsp_want.status, rsp_want.dest_index, rsp_want.src_index,
                     rsp_want.last);
            $display("%0t:          actual   status %0d dest %06h src %06h last %0b",
                     $time, rsp_if.status, rsp_if.dest_index, rsp_if.src_index,
                     rsp_if.last);
            mismatches++;
          end
        end
      end
      // A requested long hold-off lets the block fill and stall its input.
      if (hold_ack != hold_req) begin
        hold_ack = hold_req;
        stall_left = LONG_HOLD;
      end
      if (stall_left != 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        stall_left = steady ? 0 : pick_gap();
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    int unsigned aw, ah;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_ATLAS_WIDTH;
    cfg_wdata_i = '0;
    {req_if.kind, req_if.dest_x, req_if.dest_y, req_if.dest_w, req_if.dest_h} = '0;
    {req_if.crop_left, req_if.crop_top, req_if.crop_right, req_if.crop_bottom} = '0;
    {req_if.use_crop, req_if.image_w, req_if.image_h} = '0;
    req_if.valid = 1'b0;
    rsp_if.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part under the reset atlas size.
    add_req(step_item());
    // Zero size wins over the other checks.
    add_req(mk_load(4095, 0, 0, 5, 0, 0, 0, 0, 0, 8, 8));
    add_req(mk_load(0, 0, 5, 0, 0, 0, 0, 0, 0, 8, 8));
    add_req(mk_load(4095, 4095, 0, 0, 1, 4095, 0, 4095, 0, 1, 1));
    // Outside the atlas, on width, on column, on row; it wins over the crop.
    add_req(mk_load(0, 0, 8191, 1, 0, 0, 0, 0, 0, 8191, 8191));
    add_req(mk_load(4095, 0, 2, 1, 0, 0, 0, 0, 0, 8, 8));
    add_req(mk_load(0, 4095, 1, 2, 0, 0, 0, 0, 0, 8, 8));
    add_req(mk_load(4095, 4095, 2, 2, 1, 4095, 0, 4095, 0, 0, 0));
    // Empty crop: exact width, zero image, exact height.
    add_req(mk_load(0, 0, 4, 4, 1, 3, 0, 1, 0, 4, 8));
    add_req(mk_load(0, 0, 4, 4, 0, 4095, 4095, 4095, 4095, 0, 5));
    add_req(mk_load(0, 0, 4, 4, 1, 0, 4095, 0, 4095, 8, 8190));
    // Corner pixel with the widest source: the source index wraps.
    add_req(mk_load(4095, 4095, 1, 1, 1, 4095, 4095, 0, 0, 8191, 8191));
    add_req(step_item());
    add_req(step_item());
    // A sprite replaced mid-walk, then dropped by a rejected load.
    add_req(mk_load(10, 20, 3, 2, 1, 1, 2, 3, 1, 13, 9));
    add_req(step_item());
    add_req(step_item());
    add_req(mk_load(0, 0, 4096, 4096, 0, 4095, 4095, 4095, 4095, 8191, 3));
    repeat (3) add_req(step_item());
    add_req(mk_load(0, 0, 0, 3, 0, 0, 0, 0, 0, 8, 8));
    add_req(step_item());
    // Upscaling from a tiny source.
    add_req(mk_load(100, 100, 5, 3, 0, 0, 0, 0, 0, 2, 1));
    repeat (2) add_req(step_item());
    wait_idle();

    // Random phases; each may leave a sprite open across an atlas change.
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin aw = 1; ah = 1; end
        1: begin aw = MAX_DIM; ah = 1; end
        2: begin aw = 1; ah = MAX_DIM; end
        3: begin aw = MAX_DIM; ah = MAX_DIM; end
        PHASES - 1: begin aw = $urandom_range(1, 64); ah = $urandom_range(1, 64); end
        default: begin aw = $urandom_range(1, MAX_DIM); ah = $urandom_range(1, MAX_DIM); end
      endcase
      if (ph < 4 || $urandom_range(0, 1) != 0) write_atlas(REG_ATLAS_WIDTH, aw);
      if (ph < 4 || $urandom_range(0, 1) != 0) write_atlas(REG_ATLAS_HEIGHT, ah);
      @(negedge clk_i);
      steady = (ph % 3 == 1) || (ph == 4);
      if (ph == 4) begin
        hold_req++;
      end
      queue_phase(PHASE_ITEMS);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ssbag_pkg.sv
rtl/ssbag_ifs.sv
rtl/ssbag_div.sv
rtl/ssbag_ctrl.sv
rtl/ssbag_dp.sv
rtl/scaled_sprite_blit_address_gen.sv
tb/sv/tb.sv
